>>> hdl/scib_pkg.sv
// Shared types and constants for the strike-count address blocklist.
// Holds the controller state type, the command and status structs and field widths.
// Used by the controller, the datapath and the top level.
package scib_pkg;

   localparam int ADDR_W  = 32;
   localparam int COUNT_W = 8;

   localparam logic [COUNT_W-1:0] COUNT_MAX   = 8'd255;
   localparam logic [COUNT_W-1:0] COUNT_ONE   = 8'd1;
   localparam logic [COUNT_W-1:0] COUNT_ZERO  = 8'd0;
   localparam logic [COUNT_W-1:0] LIMIT_RESET = 8'd5;

   localparam logic KIND_CHECK  = 1'b0;
   localparam logic KIND_STRIKE = 1'b1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DECIDE,
      ST_RESP
   } state_type;

   typedef struct packed {
      logic load;
      logic scan_step;
      logic update;
   } cmd_type;

   typedef struct packed {
      logic scan_end;
   } status_type;

endpackage

>>> hdl/scib_if.sv
// Handshake channel interfaces for the blocklist requests and responses.
// Each carries valid, ready and the transaction payload; depends on scib_pkg.
interface scib_req_if import scib_pkg::*; ();
   logic              valid;
   logic              ready;
   logic              kind;
   logic [ADDR_W-1:0] ip_addr;

   modport source (output valid, output kind, output ip_addr, input ready);
   modport sink (input valid, input kind, input ip_addr, output ready);
endinterface

interface scib_rsp_if import scib_pkg::*; ();
   logic               valid;
   logic               ready;
   logic               listed;
   logic               promoted;
   logic [COUNT_W-1:0] strike_count;
   logic               table_full;

   modport source (output valid, output listed, output promoted, output strike_count,
                   output table_full, input ready);
   modport sink (input valid, input listed, input promoted, input strike_count,
                 input table_full, output ready);
endinterface

>>> hdl/scib_ctrl.sv
// Controller state machine for the blocklist: accept, table scan, decide, respond.
// Drives the datapath through cmd_type and reads status_type; depends on scib_pkg.
module scib_ctrl import scib_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output cmd_type    cmd,
   input  status_type st
);

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (st.scan_end) begin
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            state_in = ST_RESP;
         end
         ST_RESP: begin
            if (rsp_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      req_ready     = 1'b0;
      rsp_valid     = 1'b0;
      cmd           = '0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            cmd.load  = req_valid;
         end
         ST_SCAN: begin
            cmd.scan_step = !st.scan_end;
         end
         ST_DECIDE: begin
            cmd.update = 1'b1;
         end
         ST_RESP: begin
            rsp_valid = 1'b1;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

   a_load_starts_scan: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (state_ff == ST_SCAN))
      else $error("accepted transaction did not start a table scan");

   a_update_then_resp: assert property (@(posedge clock) disable iff (reset)
      cmd.update |=> rsp_valid)
      else $error("table update was not followed by a response");

   a_resp_holds: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && !req_ready))
      else $error("pending response dropped or new request accepted");

endmodule

>>> hdl/scib_dpath.sv
// Datapath for the blocklist: block and tracking table memories, valid bits, scan
// pipeline, limit register and response registers. Controlled by scib_ctrl via
// cmd_type and status_type; depends on scib_pkg.
module scib_dpath import scib_pkg::*; #(
   parameter int BLOCK_DEPTH = 256,
   parameter int TRACK_DEPTH = 64
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_wr_en,
   input  logic [COUNT_W-1:0] csr_wr_data,
   input  logic               req_kind,
   input  logic [ADDR_W-1:0]  req_ip_addr,
   input  cmd_type            cmd,
   output status_type         st,
   output logic               rsp_listed,
   output logic               rsp_promoted,
   output logic [COUNT_W-1:0] rsp_strike_count,
   output logic               rsp_table_full
);

   localparam int BLK_AW = $clog2(BLOCK_DEPTH);
   localparam int TRK_AW = $clog2(TRACK_DEPTH);
   localparam int SCAN_N = (BLOCK_DEPTH > TRACK_DEPTH) ? BLOCK_DEPTH : TRACK_DEPTH;
   localparam int SCAN_W = $clog2(SCAN_N + 1);

   logic [ADDR_W-1:0]      blk_mem [BLOCK_DEPTH];
   logic [ADDR_W-1:0]      trk_addr_mem [TRACK_DEPTH];
   logic [COUNT_W-1:0]     trk_cnt_mem [TRACK_DEPTH];

   logic [BLOCK_DEPTH-1:0] blk_valid_ff, blk_valid_in;
   logic [TRACK_DEPTH-1:0] trk_valid_ff, trk_valid_in;
   logic [COUNT_W-1:0]     limit_ff, limit_in;

   logic                   kind_ff;
   logic [ADDR_W-1:0]      addr_ff;
   logic [SCAN_W-1:0]      cnt_ff, cnt_in;

   logic                   blk_issue, trk_issue;
   logic [BLK_AW-1:0]      blk_rd_idx;
   logic [TRK_AW-1:0]      trk_rd_idx;
   logic [ADDR_W-1:0]      blk_rd_ff;
   logic [ADDR_W-1:0]      trk_rd_ff;
   logic [COUNT_W-1:0]     trk_cnt_rd_ff;

   logic                   blk_live_ff, blk_live_in;
   logic                   blk_ent_ff, blk_ent_in;
   logic [BLK_AW-1:0]      blk_idx_ff, blk_idx_in;
   logic                   trk_live_ff, trk_live_in;
   logic                   trk_ent_ff, trk_ent_in;
   logic [TRK_AW-1:0]      trk_idx_ff, trk_idx_in;

   logic                   blk_hit_ff, blk_hit_in;
   logic                   blk_free_ff, blk_free_in;
   logic [BLK_AW-1:0]      blk_free_idx_ff, blk_free_idx_in;
   logic                   trk_hit_ff, trk_hit_in;
   logic [TRK_AW-1:0]      trk_hit_idx_ff, trk_hit_idx_in;
   logic [COUNT_W-1:0]     trk_hit_cnt_ff, trk_hit_cnt_in;
   logic                   trk_free_ff, trk_free_in;
   logic [TRK_AW-1:0]      trk_free_idx_ff, trk_free_idx_in;

   logic                   strike_path, has_t, need_prom, prom;
   logic [TRK_AW-1:0]      trk_sel;
   logic [COUNT_W-1:0]     new_cnt;
   logic                   res_listed, res_full;
   logic [COUNT_W-1:0]     res_count;

   logic                   rsp_listed_ff, rsp_promoted_ff, rsp_full_ff;
   logic [COUNT_W-1:0]     rsp_count_ff;

   // Scan issue: one entry of each table is read per cycle until that table has been read through.
   assign blk_issue  = cmd.scan_step && (cnt_ff < SCAN_W'(BLOCK_DEPTH));
   assign trk_issue  = cmd.scan_step && (cnt_ff < SCAN_W'(TRACK_DEPTH));
   assign blk_rd_idx = cnt_ff[BLK_AW-1:0];
   assign trk_rd_idx = cnt_ff[TRK_AW-1:0];
   assign st.scan_end = (cnt_ff == SCAN_W'(SCAN_N));

   always_comb begin
      cnt_in = cnt_ff;
      if (cmd.load) begin
         cnt_in = '0;
      end else if (cmd.scan_step) begin
         cnt_in = cnt_ff + SCAN_W'(1);
      end
      blk_live_in = blk_issue;
      blk_ent_in  = blk_valid_ff[blk_rd_idx];
      blk_idx_in  = blk_rd_idx;
      trk_live_in = trk_issue;
      trk_ent_in  = trk_valid_ff[trk_rd_idx];
      trk_idx_in  = trk_rd_idx;
   end

   // Compare stage: keep the first match and the lowest free entry of each table.
   always_comb begin
      blk_hit_in      = blk_hit_ff;
      blk_free_in     = blk_free_ff;
      blk_free_idx_in = blk_free_idx_ff;
      trk_hit_in      = trk_hit_ff;
      trk_hit_idx_in  = trk_hit_idx_ff;
      trk_hit_cnt_in  = trk_hit_cnt_ff;
      trk_free_in     = trk_free_ff;
      trk_free_idx_in = trk_free_idx_ff;
      if (cmd.load) begin
         blk_hit_in  = 1'b0;
         blk_free_in = 1'b0;
         trk_hit_in  = 1'b0;
         trk_free_in = 1'b0;
      end else begin
         if (blk_live_ff && blk_ent_ff && (blk_rd_ff == addr_ff)) begin
            blk_hit_in = 1'b1;
         end
         if (blk_live_ff && !blk_ent_ff && !blk_free_ff) begin
            blk_free_in     = 1'b1;
            blk_free_idx_in = blk_idx_ff;
         end
         if (trk_live_ff && trk_ent_ff && (trk_rd_ff == addr_ff) && !trk_hit_ff) begin
            trk_hit_in     = 1'b1;
            trk_hit_idx_in = trk_idx_ff;
            trk_hit_cnt_in = trk_cnt_rd_ff;
         end
         if (trk_live_ff && !trk_ent_ff && !trk_free_ff) begin
            trk_free_in     = 1'b1;
            trk_free_idx_in = trk_idx_ff;
         end
      end
   end

   // Decision for the transaction once both tables have been scanned.
   always_comb begin
      strike_path = !blk_hit_ff && (kind_ff == KIND_STRIKE);
      has_t       = strike_path && (trk_hit_ff || trk_free_ff);
      trk_sel     = trk_hit_ff ? trk_hit_idx_ff : trk_free_idx_ff;
      if (trk_hit_ff) begin
         new_cnt = (trk_hit_cnt_ff == COUNT_MAX) ? COUNT_MAX : trk_hit_cnt_ff + COUNT_ONE;
      end else begin
         new_cnt = COUNT_ONE;
      end
      need_prom  = has_t && (new_cnt > limit_ff);
      prom       = need_prom && blk_free_ff;
      res_listed = blk_hit_ff || prom;
      res_full   = strike_path && (!has_t || (need_prom && !blk_free_ff));
      res_count  = COUNT_ZERO;
      if (!blk_hit_ff) begin
         if (kind_ff == KIND_CHECK) begin
            res_count = trk_hit_ff ? trk_hit_cnt_ff : COUNT_ZERO;
         end else if (has_t && !prom) begin
            res_count = new_cnt;
         end
      end
   end

   always_comb begin
      blk_valid_in = blk_valid_ff;
      trk_valid_in = trk_valid_ff;
      limit_in     = csr_wr_en ? csr_wr_data : limit_ff;
      if (cmd.update && has_t) begin
         trk_valid_in[trk_sel] = !prom;
      end
      if (cmd.update && prom) begin
         blk_valid_in[blk_free_idx_ff] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         blk_valid_ff <= '0;
         trk_valid_ff <= '0;
         limit_ff     <= LIMIT_RESET;
         cnt_ff       <= SCAN_W'(SCAN_N);
         blk_live_ff  <= 1'b0;
         trk_live_ff  <= 1'b0;
         blk_hit_ff   <= 1'b0;
         blk_free_ff  <= 1'b0;
         trk_hit_ff   <= 1'b0;
         trk_free_ff  <= 1'b0;
      end else begin
         blk_valid_ff <= blk_valid_in;
         trk_valid_ff <= trk_valid_in;
         limit_ff     <= limit_in;
         cnt_ff       <= cnt_in;
         blk_live_ff  <= blk_live_in;
         trk_live_ff  <= trk_live_in;
         blk_hit_ff   <= blk_hit_in;
         blk_free_ff  <= blk_free_in;
         trk_hit_ff   <= trk_hit_in;
         trk_free_ff  <= trk_free_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         kind_ff <= req_kind;
         addr_ff <= req_ip_addr;
      end
      blk_ent_ff      <= blk_ent_in;
      blk_idx_ff      <= blk_idx_in;
      trk_ent_ff      <= trk_ent_in;
      trk_idx_ff      <= trk_idx_in;
      blk_free_idx_ff <= blk_free_idx_in;
      trk_hit_idx_ff  <= trk_hit_idx_in;
      trk_hit_cnt_ff  <= trk_hit_cnt_in;
      trk_free_idx_ff <= trk_free_idx_in;
      if (cmd.update) begin
         rsp_listed_ff   <= res_listed;
         rsp_promoted_ff <= prom;
         rsp_count_ff    <= res_count;
         rsp_full_ff     <= res_full;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.update && prom) begin
         blk_mem[blk_free_idx_ff] <= addr_ff;
      end
      if (blk_issue) begin
         blk_rd_ff <= blk_mem[blk_rd_idx];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.update && has_t) begin
         trk_addr_mem[trk_sel] <= addr_ff;
         trk_cnt_mem[trk_sel]  <= new_cnt;
      end
      if (trk_issue) begin
         trk_rd_ff     <= trk_addr_mem[trk_rd_idx];
         trk_cnt_rd_ff <= trk_cnt_mem[trk_rd_idx];
      end
   end

   assign rsp_listed       = rsp_listed_ff;
   assign rsp_promoted     = rsp_promoted_ff;
   assign rsp_strike_count = rsp_count_ff;
   assign rsp_table_full   = rsp_full_ff;

   a_load_clears_scan: assert property (@(posedge clock) disable iff (reset)
      cmd.load |=> (cnt_ff == '0) && !blk_hit_ff && !trk_hit_ff)
      else $error("scan state not cleared on a new transaction");

   a_promote_shape: assert property (@(posedge clock) disable iff (reset)
      cmd.update |=> (!rsp_promoted_ff || (rsp_listed_ff && (rsp_count_ff == COUNT_ZERO))))
      else $error("promotion reported without listing or with a nonzero count");

   a_check_never_full: assert property (@(posedge clock) disable iff (reset)
      (cmd.update && (kind_ff == KIND_CHECK)) |=> !rsp_full_ff)
      else $error("membership check reported a full table");

   a_block_grows_on_promote: assert property (@(posedge clock) disable iff (reset)
      cmd.update |=> ($countones(blk_valid_ff) ==
                      $countones($past(blk_valid_ff)) + (rsp_promoted_ff ? 1 : 0)))
      else $error("block table occupancy does not match the promotion flag");

endmodule

>>> hdl/strike_count_ip_blocklist.sv
// Top level of the strike-count address blocklist.
// Instantiates scib_ctrl and scib_dpath on scib_req_if and scib_rsp_if; depends on scib_pkg.
//
// Each request transaction carries an IPv4 address and a kind, check or strike, and
// produces exactly one response transaction. The block holds a permanent block table of
// BLOCK_DEPTH addresses and a tracking table of TRACK_DEPTH addresses with strike counts.
// Both tables are scanned together, one entry of each per cycle through the read port of
// each table memory until that table has been read through; a new request is accepted
// only after the response to the last one has been taken. Valid bits clear at reset;
// there is no clearing pass. The strike limit is written through csr_wr_en and csr_wr_data;
// the user must write it only while the block is idle; the block itself does not enforce it.
module strike_count_ip_blocklist import scib_pkg::*; #(
   parameter int BLOCK_DEPTH = 256,
   parameter int TRACK_DEPTH = 64
) (
   input  logic               clock,
   input  logic               reset,
   scib_req_if.sink           req_if,
   scib_rsp_if.source         rsp_if,
   input  logic               csr_wr_en,
   input  logic [COUNT_W-1:0] csr_wr_data
);

   cmd_type    cmd;
   status_type st;

   scib_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_ready (req_if.ready),
      .rsp_valid (rsp_if.valid),
      .rsp_ready (rsp_if.ready),
      .cmd       (cmd),
      .st        (st)
   );

   scib_dpath #(
      .BLOCK_DEPTH (BLOCK_DEPTH),
      .TRACK_DEPTH (TRACK_DEPTH)
   ) u_dpath (
      .clock            (clock),
      .reset            (reset),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data),
      .req_kind         (req_if.kind),
      .req_ip_addr      (req_if.ip_addr),
      .cmd              (cmd),
      .st               (st),
      .rsp_listed       (rsp_if.listed),
      .rsp_promoted     (rsp_if.promoted),
      .rsp_strike_count (rsp_if.strike_count),
      .rsp_table_full   (rsp_if.table_full)
   );

endmodule

>>> test/scib_outcome_checker.sv
`timescale 1ns / 1ps
// Checker for the strike-count address blocklist: watches both channels and the strike limit port.
// Predicts each response from its own copy of the block and tracking tables and compares them.
// Depends on scib_pkg and the channel interfaces in scib_if.sv.
module scib_outcome_checker import scib_pkg::*; #(
   parameter int BLOCK_DEPTH = 256,
   parameter int TRACK_DEPTH = 64
) (
   input  logic               clock,
   input  logic               reset,
   scib_req_if                req_mon,
   scib_rsp_if                rsp_mon,
   input  logic               csr_wr_en,
   input  logic [COUNT_W-1:0] csr_wr_data,
   output int                 outcomes_due,
   output int                 mismatch_count
);

   typedef struct packed {
      logic               listed;
      logic               promoted;
      logic [COUNT_W-1:0] strike_count;
      logic               table_full;
   } outcome_type;

   logic [ADDR_W-1:0]  blocked_addr [BLOCK_DEPTH];
   logic               blocked_live [BLOCK_DEPTH];
   logic [ADDR_W-1:0]  watched_addr [TRACK_DEPTH];
   logic [COUNT_W-1:0] watched_count [TRACK_DEPTH];
   logic               watched_live [TRACK_DEPTH];
   logic [COUNT_W-1:0] limit_copy;
   outcome_type        due_outcomes [$];
   outcome_type        got;
   outcome_type        want;

   function automatic outcome_type apply_attempt(logic kind, logic [ADDR_W-1:0] addr);
      outcome_type res;
      int          blk_hit;
      int          trk;
      int          free_blk;
      res = '0;
      blk_hit = -1;
      trk = -1;
      free_blk = -1;
      for (int i = 0; i < BLOCK_DEPTH; i++)
         if (blk_hit < 0 && blocked_live[i] && blocked_addr[i] == addr) blk_hit = i;
      for (int i = 0; i < TRACK_DEPTH; i++)
         if (trk < 0 && watched_live[i] && watched_addr[i] == addr) trk = i;
      if (blk_hit >= 0) begin
         res.listed = 1'b1;
      end else if (kind == KIND_CHECK) begin
         if (trk >= 0) res.strike_count = watched_count[trk];
      end else begin
         if (trk < 0) begin
            for (int i = 0; i < TRACK_DEPTH; i++)
               if (trk < 0 && !watched_live[i]) trk = i;
            if (trk < 0) begin
               res.table_full = 1'b1;
            end else begin
               watched_live[trk] = 1'b1;
               watched_addr[trk] = addr;
               watched_count[trk] = COUNT_ONE;
            end
         end else if (watched_count[trk] != COUNT_MAX) begin
            watched_count[trk] = watched_count[trk] + COUNT_ONE;
         end
         if (trk >= 0) begin
            res.strike_count = watched_count[trk];
            if (watched_count[trk] > limit_copy) begin
               for (int i = 0; i < BLOCK_DEPTH; i++)
                  if (free_blk < 0 && !blocked_live[i]) free_blk = i;
               if (free_blk < 0) begin
                  res.table_full = 1'b1;
               end else begin
                  blocked_live[free_blk] = 1'b1;
                  blocked_addr[free_blk] = addr;
                  watched_live[trk] = 1'b0;
                  res.listed = 1'b1;
                  res.promoted = 1'b1;
                  res.strike_count = COUNT_ZERO;
               end
            end
         end
      end
      return res;
   endfunction

   task automatic report_mismatch(string what, outcome_type exp_res, outcome_type act_res);
      if (mismatch_count < 10) begin
         $write("%0t ERROR %s: expected listed=%0d promoted=%0d strike_count=%0d ",
                $time, what, exp_res.listed, exp_res.promoted, exp_res.strike_count);
         $display("table_full=%0d, got listed=%0d promoted=%0d strike_count=%0d table_full=%0d",
                  exp_res.table_full, act_res.listed, act_res.promoted,
                  act_res.strike_count, act_res.table_full);
      end
      mismatch_count++;
   endtask

   always @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < BLOCK_DEPTH; i++) blocked_live[i] = 1'b0;
         for (int i = 0; i < TRACK_DEPTH; i++) watched_live[i] = 1'b0;
         limit_copy = LIMIT_RESET;
         due_outcomes.delete();
         mismatch_count = 0;
         outcomes_due <= 0;
      end else begin
         if (rsp_mon.valid && rsp_mon.ready) begin
            got.listed = rsp_mon.listed;
            got.promoted = rsp_mon.promoted;
            got.strike_count = rsp_mon.strike_count;
            got.table_full = rsp_mon.table_full;
            if (due_outcomes.size() == 0) begin
               report_mismatch("response transaction with no request outstanding", '0, got);
            end else begin
               want = due_outcomes.pop_front();
               if (got.listed !== want.listed || got.promoted !== want.promoted ||
                   got.strike_count !== want.strike_count ||
                   got.table_full !== want.table_full)
                  report_mismatch("response transaction mismatch", want, got);
            end
         end
         if (req_mon.valid && req_mon.ready)
            due_outcomes.push_back(apply_attempt(req_mon.kind, req_mon.ip_addr));
         if (csr_wr_en) limit_copy = csr_wr_data;
         outcomes_due <= due_outcomes.size();
      end
   end

endmodule

>>> test/strike_count_ip_blocklist_test.sv
`timescale 1ns / 1ps
// Top of the blocklist testbench: clock, reset, request stimulus, response stalls and verdict.
// Instantiates strike_count_ip_blocklist as dut and scib_outcome_checker beside it.
// Depends on scib_pkg and the channel interfaces in scib_if.sv.
module strike_count_ip_blocklist_test import scib_pkg::*; ();

   localparam int STALL_LIMIT  = 20000;
   localparam int DRAIN_CYCLES = 300;
   localparam int POOL_SIZE    = 8;

   typedef enum int {
      PACE_NONE,
      PACE_SENDER,
      PACE_RECEIVER,
      PACE_BOTH
   } pace_mode_type;

   logic               clock;
   logic               reset;
   logic               csr_wr_en;
   logic [COUNT_W-1:0] csr_wr_data;
   int                 outcomes_due;
   int                 mismatch_count;
   int                 quiet_cycles = 0;
   int                 send_idle_pct = 0;
   int                 recv_stall_pct = 0;
   logic [ADDR_W-1:0]  addr_pool [POOL_SIZE];
   logic [ADDR_W-1:0]  promoted_addrs [$];

   localparam logic [ADDR_W-1:0] HAMMER_ADDR = 32'h55AA_AA55;

   scib_req_if req_ch ();
   scib_rsp_if rsp_ch ();

   strike_count_ip_blocklist dut (
      .clock       (clock),
      .reset       (reset),
      .req_if      (req_ch),
      .rsp_if      (rsp_ch),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   scib_outcome_checker checker_inst (
      .clock          (clock),
      .reset          (reset),
      .req_mon        (req_ch),
      .rsp_mon        (rsp_ch),
      .csr_wr_en      (csr_wr_en),
      .csr_wr_data    (csr_wr_data),
      .outcomes_due   (outcomes_due),
      .mismatch_count (mismatch_count)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   always @(posedge clock) begin
      rsp_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
   end

   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   task automatic set_pace(pace_mode_type mode);
      case (mode)
         PACE_NONE: begin
            send_idle_pct = 0;
            recv_stall_pct = 0;
         end
         PACE_SENDER: begin
            send_idle_pct = 82;
            recv_stall_pct = 0;
         end
         PACE_RECEIVER: begin
            send_idle_pct = 0;
            recv_stall_pct = 82;
         end
         default: begin
            send_idle_pct = 13;
            recv_stall_pct = 13;
         end
      endcase
   endtask

   task automatic send_attempt(logic kind, logic [ADDR_W-1:0] addr);
      while ($urandom_range(99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.kind <= kind;
      req_ch.ip_addr <= addr;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
   endtask

   task automatic wait_for_drain();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (outcomes_due != 0) @(posedge clock);
   endtask

   task automatic set_strike_limit(logic [COUNT_W-1:0] value);
      wait_for_drain();
      csr_wr_en <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   initial begin
      logic [ADDR_W-1:0] fresh;
      int                pick;
      reset <= 1'b1;
      csr_wr_en <= 1'b0;
      csr_wr_data <= '0;
      req_ch.valid <= 1'b0;
      req_ch.kind <= KIND_CHECK;
      req_ch.ip_addr <= '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Directed transactions at the reset strike limit, then at strike limits 0 and 254.
      set_pace(PACE_NONE);
      send_attempt(KIND_CHECK, 32'h0000_0000);
      send_attempt(KIND_CHECK, 32'hFFFF_FFFF);
      repeat (6) send_attempt(KIND_STRIKE, 32'h0000_0000);
      send_attempt(KIND_CHECK, 32'h0000_0000);
      send_attempt(KIND_STRIKE, 32'h0000_0000);
      send_attempt(KIND_STRIKE, 32'hFFFF_FFFF);
      send_attempt(KIND_CHECK, 32'hFFFF_FFFF);
      set_strike_limit(8'd0);
      send_attempt(KIND_STRIKE, 32'h1234_5678);
      send_attempt(KIND_STRIKE, 32'hFFFF_FFFF);
      send_attempt(KIND_CHECK, 32'hFFFF_FFFF);
      set_strike_limit(8'd254);
      send_attempt(KIND_STRIKE, HAMMER_ADDR);
      send_attempt(KIND_STRIKE, HAMMER_ADDR);
      send_attempt(KIND_CHECK, HAMMER_ADDR);
      send_attempt(KIND_STRIKE, 32'hAAAA_5555);
      send_attempt(KIND_CHECK, 32'h7FFF_FFFF);

      // Repeated strikes on a small address pool under low limits, with some noise.
      for (int phase = 0; phase < 4; phase++) begin
         set_pace(pace_mode_type'(phase));
         if (phase == 3)
            set_strike_limit(COUNT_W'($urandom_range(1, 8)));
         else
            set_strike_limit(COUNT_W'(phase + 1));
         for (int i = 0; i < POOL_SIZE; i++) addr_pool[i] = $urandom();
         repeat (50) begin
            pick = $urandom_range(99);
            if (pick < 60)
               send_attempt(KIND_STRIKE, addr_pool[$urandom_range(POOL_SIZE - 1)]);
            else if (pick < 85)
               send_attempt(KIND_CHECK, addr_pool[$urandom_range(POOL_SIZE - 1)]);
            else
               send_attempt($urandom_range(1) == 1 ? KIND_STRIKE : KIND_CHECK, $urandom());
         end
      end

      // Every strike promotes until the block table fills, then the tracking table fills.
      set_pace(PACE_BOTH);
      set_strike_limit(8'd0);
      repeat (330) begin
         fresh = $urandom();
         send_attempt(KIND_STRIKE, fresh);
         if (promoted_addrs.size() < 32) promoted_addrs.push_back(fresh);
      end

      // With the block table full, one tracked address is struck until its count saturates.
      set_pace(PACE_RECEIVER);
      repeat (260) begin
         send_attempt(KIND_STRIKE, HAMMER_ADDR);
         if ($urandom_range(9) == 0) send_attempt(KIND_CHECK, HAMMER_ADDR);
      end

      set_pace(PACE_SENDER);
      set_strike_limit(8'd254);
      repeat (50) begin
         pick = $urandom_range(99);
         if (pick < 40)
            send_attempt(KIND_CHECK, promoted_addrs[$urandom_range(promoted_addrs.size() - 1)]);
         else if (pick < 60)
            send_attempt(KIND_CHECK, HAMMER_ADDR);
         else if (pick < 80)
            send_attempt(KIND_STRIKE, HAMMER_ADDR);
         else
            send_attempt($urandom_range(1) == 1 ? KIND_STRIKE : KIND_CHECK, $urandom());
      end

      wait_for_drain();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule
